/* sv/facu_pkg.sv */
// Package with the shared constants and types of the frustum box culling unit.
`timescale 1ns / 1ps
`default_nettype none

package facu_pkg;

   localparam int NUM_REGS   = 8;
   localparam int REG_W      = 64;
   localparam int REG_IDX_W  = 3;
   localparam int ENTRY_W    = 32;
   localparam int COEF_W     = ENTRY_W + 1;
   localparam int CHUNK_W    = 12;
   localparam int NUM_PLANES = 6;
   localparam int NUM_COLS   = 4;
   localparam int NUM_AXES   = 3;

   typedef logic [REG_W-1:0]           reg_word_type;
   typedef logic [REG_IDX_W-1:0]       reg_idx_type;
   typedef logic signed [COEF_W-1:0]   coef_type;
   typedef logic signed [CHUNK_W-1:0]  chunk_type;

   typedef enum logic [REG_IDX_W-1:0] {
      ROW0_XY, ROW0_ZW, ROW1_XY, ROW1_ZW, ROW2_XY, ROW2_ZW, ROW3_XY, ROW3_ZW
   } matrix_reg_type;

endpackage

`default_nettype wire

/* sv/frustum_aabb_cull_unit.sv */
// Top level of the frustum box culling unit: matrix registers and cull pipeline.
`timescale 1ns / 1ps
`default_nettype none

//  Channel   Direction  Handshake             Payload
//  req_      in         req_valid/req_ready   req_chunk_x, req_chunk_z
//  rsp_      out        rsp_valid/rsp_ready   rsp_visible
//  csr_      in         csr_we                csr_index, csr_wdata
//
// One transaction enters per cycle while the pipeline is not held.
// The stages are box corners, eighteen coefficient products, paired sums and
// the final sign test, which feeds the output register.
// Reset clears the matrix registers and all valid bits.
// When the output register is full and not taken, the whole pipeline holds.

module frustum_aabb_cull_unit
   import facu_pkg::*;
#(
   parameter int CHUNK_EDGE = 16,
   parameter int CHUNK_TALL = 256
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic signed [CHUNK_W-1:0]  req_chunk_x,
   input  wire logic signed [CHUNK_W-1:0]  req_chunk_z,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic                            rsp_visible,
   input  wire logic                       csr_we,
   input  wire logic [REG_IDX_W-1:0]       csr_index,
   input  wire logic [REG_W-1:0]           csr_wdata
);

   localparam int XZ_MAG = (1 << (CHUNK_W - 1)) * CHUNK_EDGE + CHUNK_EDGE;
   localparam int XZ_W   = $clog2(XZ_MAG + 1) + 1;
   localparam int Y_W    = $clog2(CHUNK_TALL + 1) + 1;
   localparam int AW     = (XZ_W > Y_W) ? XZ_W : Y_W;
   localparam int PW     = COEF_W + AW;
   localparam int SW     = PW + 2;

   localparam logic signed [AW-1:0] EDGE_S = AW'(CHUNK_EDGE);
   localparam logic signed [AW-1:0] HALF_S = AW'(CHUNK_EDGE / 2);
   localparam logic signed [AW-1:0] TALL_S = AW'(CHUNK_TALL);
   localparam logic signed [AW-1:0] ZERO_S = '0;

   reg_word_type cfg_ff [NUM_REGS];
   coef_type     coef_in [NUM_PLANES][NUM_COLS];
   coef_type     coef_ff [NUM_PLANES][NUM_COLS];

   logic advance;

   logic                 s1_valid_ff;
   logic signed [AW-1:0] x_lo_in, x_hi_in, z_lo_in, z_hi_in;
   logic signed [AW-1:0] x_lo_ff, x_hi_ff, z_lo_ff, z_hi_ff;

   logic                 s2_valid_ff;
   logic signed [PW-1:0] prod_in [NUM_PLANES][NUM_AXES];
   logic signed [PW-1:0] prod_ff [NUM_PLANES][NUM_AXES];

   logic                 s3_valid_ff;
   logic signed [SW-1:0] pair_a_in [NUM_PLANES];
   logic signed [SW-1:0] pair_b_in [NUM_PLANES];
   logic signed [SW-1:0] pair_a_ff [NUM_PLANES];
   logic signed [SW-1:0] pair_b_ff [NUM_PLANES];

   logic                 rsp_valid_ff;
   logic                 visible_in;
   logic                 visible_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_visible = visible_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            cfg_ff[i] <= '0;
         end
      end else if (csr_we) begin
         cfg_ff[csr_index] <= csr_wdata;
      end
   end

   always_comb begin
      coef_type e3;
      coef_type er;
      for (int p = 0; p < NUM_PLANES; p++) begin
         for (int c = 0; c < NUM_COLS; c++) begin
            e3 = COEF_W'($signed(cfg_ff[ROW3_XY + c / 2][(c % 2) * ENTRY_W +: ENTRY_W]));
            er = COEF_W'($signed(cfg_ff[(p / 2) * 2 + c / 2][(c % 2) * ENTRY_W +: ENTRY_W]));
            coef_in[p][c] = (p % 2 == 1) ? (e3 - er) : (e3 + er);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NUM_PLANES; p++) begin
            for (int c = 0; c < NUM_COLS; c++) begin
               coef_ff[p][c] <= '0;
            end
         end
      end else begin
         coef_ff <= coef_in;
      end
   end

   always_comb begin
      x_lo_in = AW'(req_chunk_x) * EDGE_S - HALF_S;
      x_hi_in = x_lo_in + EDGE_S;
      z_lo_in = AW'(req_chunk_z) * EDGE_S - HALF_S;
      z_hi_in = z_lo_in + EDGE_S;
   end

   always_comb begin
      logic signed [AW-1:0] vx, vy, vz;
      for (int p = 0; p < NUM_PLANES; p++) begin
         vx = (coef_ff[p][0] >= 0) ? x_hi_ff : x_lo_ff;
         vy = (coef_ff[p][1] >= 0) ? TALL_S  : ZERO_S;
         vz = (coef_ff[p][2] >= 0) ? z_hi_ff : z_lo_ff;
         prod_in[p][0] = PW'(coef_ff[p][0]) * PW'(vx);
         prod_in[p][1] = PW'(coef_ff[p][1]) * PW'(vy);
         prod_in[p][2] = PW'(coef_ff[p][2]) * PW'(vz);
      end
   end

   always_comb begin
      for (int p = 0; p < NUM_PLANES; p++) begin
         pair_a_in[p] = SW'(prod_ff[p][0]) + SW'(prod_ff[p][1]);
         pair_b_in[p] = SW'(prod_ff[p][2]) + SW'(coef_ff[p][3]);
      end
   end

   always_comb begin
      logic signed [SW-1:0] plane_sum;
      visible_in = 1'b1;
      for (int p = 0; p < NUM_PLANES; p++) begin
         plane_sum = pair_a_ff[p] + pair_b_ff[p];
         if (plane_sum[SW-1]) begin
            visible_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_lo_ff    <= x_lo_in;
         x_hi_ff    <= x_hi_in;
         z_lo_ff    <= z_lo_in;
         z_hi_ff    <= z_hi_in;
         prod_ff    <= prod_in;
         pair_a_ff  <= pair_a_in;
         pair_b_ff  <= pair_b_in;
         visible_ff <= visible_in;
      end
   end

`ifndef SYNTHESIS
   a_out_follows_s3: assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_valid == $past(s3_valid_ff)))
      else $error("output valid does not follow the last stage");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(s1_valid_ff) && $stable(s2_valid_ff) && $stable(s3_valid_ff)))
      else $error("pipeline moved during a stall");

   a_blocked_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("transaction accepted while the output is blocked");

   a_stall_keeps_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_visible)))
      else $error("held result changed");
`endif

endmodule

`default_nettype wire

/* sim/frustum_aabb_cull_unit_test.sv */
// Self-checking testbench for the frustum box culling unit: directed table, random phases.
`timescale 1ns / 1ps

module frustum_aabb_cull_unit_test
   import facu_pkg::*;
();

   localparam int CHUNK_EDGE      = 16;
   localparam int CHUNK_TALL      = 256;
   localparam int DRAIN_CYCLES    = 8;
   localparam int TAIL_CYCLES     = 16;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int STALL_LIMIT     = 2000;
   localparam int PHASE_ITEMS     = 250;
   localparam int NUM_PHASES      = 7;
   localparam int NUM_DIRECTED    = 22;

   typedef enum {
      MAT_RESET, MAT_EDGE, MAT_BEHIND, MAT_ALL_NEG_LSB, MAT_MAX, MAT_MIN,
      MAT_MAX_MIN, MAT_MIN_MAX, MAT_CAMERA, MAT_NOISE
   } matrix_kind_type;

   typedef logic signed [ENTRY_W-1:0] entry_type;
   typedef entry_type matrix_type [4][NUM_COLS];

   typedef struct {
      matrix_kind_type kind;
      chunk_type       cx;
      chunk_type       cz;
      bit              known;
      bit              visible;
   } directed_row_type;

   localparam entry_type ENTRY_ONE     = 32'sh0001_0000;
   localparam entry_type ENTRY_MAX     = 32'sh7FFF_FFFF;
   localparam entry_type ENTRY_MIN     = 32'sh8000_0000;
   localparam entry_type ENTRY_NEG_LSB = 32'shFFFF_FFFF;
   localparam entry_type ENTRY_MINUS_8 = 32'shFFF8_0000;

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         req_valid   = 1'b0;
   logic         req_ready;
   chunk_type    req_chunk_x = '0;
   chunk_type    req_chunk_z = '0;
   logic         rsp_valid;
   logic         rsp_ready   = 1'b0;
   logic         rsp_visible;
   logic         csr_we      = 1'b0;
   reg_idx_type  csr_index   = '0;
   reg_word_type csr_wdata   = '0;

   matrix_type matrix_model;
   bit         expected_visibility [$];
   int         mismatch_count = 0;
   int         send_idle_pct  = 11;
   int         recv_idle_pct  = 61;
   bit         hold_off_armed = 1'b0;
   bit         hold_off_taken = 1'b0;
   int         quiet_cycles   = 0;

   directed_row_type directed_rows [NUM_DIRECTED] = '{
      '{MAT_RESET,       -2048, -2048, 1'b1, 1'b1},
      '{MAT_RESET,        2047,  2047, 1'b1, 1'b1},
      '{MAT_RESET,       -2048,  2047, 1'b1, 1'b1},
      '{MAT_RESET,           0,     0, 1'b1, 1'b1},
      '{MAT_RESET,          -1,     1, 1'b1, 1'b1},
      '{MAT_EDGE,            0, -2048, 1'b1, 1'b1},
      '{MAT_EDGE,           -1,  2047, 1'b1, 1'b0},
      '{MAT_EDGE,         2047,     0, 1'b1, 1'b1},
      '{MAT_EDGE,        -2048,     5, 1'b1, 1'b0},
      '{MAT_BEHIND,          0,     0, 1'b1, 1'b0},
      '{MAT_BEHIND,       2047, -2048, 1'b1, 1'b0},
      '{MAT_ALL_NEG_LSB,     0,     0, 1'b0, 1'b0},
      '{MAT_ALL_NEG_LSB,  2047,  2047, 1'b0, 1'b0},
      '{MAT_ALL_NEG_LSB, -2048, -2048, 1'b0, 1'b0},
      '{MAT_MAX,             0,     0, 1'b0, 1'b0},
      '{MAT_MAX,         -2048,  2047, 1'b0, 1'b0},
      '{MAT_MIN,             0,     0, 1'b0, 1'b0},
      '{MAT_MIN,          2047, -2048, 1'b0, 1'b0},
      '{MAT_MAX_MIN,         1,    -1, 1'b0, 1'b0},
      '{MAT_MAX_MIN,     -2048, -2048, 1'b0, 1'b0},
      '{MAT_MIN_MAX,         0,     0, 1'b0, 1'b0},
      '{MAT_MIN_MAX,      2047,  2047, 1'b0, 1'b0}
   };

   matrix_kind_type phase_kinds [NUM_PHASES] = '{
      MAT_CAMERA, MAT_NOISE, MAT_CAMERA, MAT_CAMERA, MAT_NOISE, MAT_CAMERA, MAT_CAMERA
   };

   frustum_aabb_cull_unit #(
      .CHUNK_EDGE(CHUNK_EDGE),
      .CHUNK_TALL(CHUNK_TALL)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_chunk_x(req_chunk_x),
      .req_chunk_z(req_chunk_z),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_visible(rsp_visible),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic bit predict_visible(chunk_type cx, chunk_type cz);
      longint lo [3];
      longint hi [3];
      longint coef;
      longint plane_sum;
      int     r;
      lo[0] = longint'(cx) * CHUNK_EDGE - CHUNK_EDGE / 2;
      hi[0] = lo[0] + CHUNK_EDGE;
      lo[1] = 0;
      hi[1] = CHUNK_TALL;
      lo[2] = longint'(cz) * CHUNK_EDGE - CHUNK_EDGE / 2;
      hi[2] = lo[2] + CHUNK_EDGE;
      for (int p = 0; p < NUM_PLANES; p++) begin
         r = p / 2;
         plane_sum = 0;
         for (int a = 0; a < NUM_COLS; a++) begin
            if (p % 2)
               coef = longint'(matrix_model[3][a]) - longint'(matrix_model[r][a]);
            else
               coef = longint'(matrix_model[3][a]) + longint'(matrix_model[r][a]);
            if (a == NUM_AXES)
               plane_sum += coef;
            else
               plane_sum += coef * (coef >= 0 ? hi[a] : lo[a]);
         end
         if (plane_sum < 0)
            return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic int signed_span(int span);
      return int'($urandom_range(2 * span)) - span;
   endfunction

   function automatic entry_type noise_entry();
      case ($urandom_range(6))
         0: return '0;
         1: return ENTRY_ONE;
         2: return -ENTRY_ONE;
         3: return ENTRY_MAX;
         4: return ENTRY_MIN;
         5: return ENTRY_NEG_LSB;
         default: return entry_type'($urandom);
      endcase
   endfunction

   function automatic matrix_type build_matrix(matrix_kind_type kind);
      matrix_type e;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < NUM_COLS; c++) begin
            case (kind)
               MAT_ALL_NEG_LSB: e[r][c] = ENTRY_NEG_LSB;
               MAT_MAX:         e[r][c] = ENTRY_MAX;
               MAT_MIN:         e[r][c] = ENTRY_MIN;
               MAT_MAX_MIN:     e[r][c] = (r == 3) ? ENTRY_MAX : ENTRY_MIN;
               MAT_MIN_MAX:     e[r][c] = (r == 3) ? ENTRY_MIN : ENTRY_MAX;
               MAT_NOISE:       e[r][c] = noise_entry();
               MAT_CAMERA: begin
                  if (r == 3 && c == 3)
                     e[r][c] = int'($urandom_range(400, 100)) * 65536;
                  else if (r == 3)
                     e[r][c] = signed_span(16384);
                  else if (c == 3)
                     e[r][c] = signed_span(50 * 65536);
                  else
                     e[r][c] = signed_span(65536);
               end
               default:         e[r][c] = '0;
            endcase
         end
      end
      if (kind == MAT_EDGE) begin
         e[3][0] = ENTRY_ONE;
         e[3][3] = ENTRY_MINUS_8;
      end
      if (kind == MAT_BEHIND)
         e[3][3] = ENTRY_NEG_LSB;
      return e;
   endfunction

   function automatic chunk_type random_chunk();
      if ($urandom_range(99) < 15)
         return chunk_type'($urandom);
      return chunk_type'(signed_span(24));
   endfunction

   task automatic load_matrix(matrix_type e);
      reg_word_type   word;
      matrix_reg_type idx;
      for (int i = 0; i < NUM_REGS; i++) begin
         idx = matrix_reg_type'(i);
         case (idx)
            ROW0_XY: word = {e[0][1], e[0][0]};
            ROW0_ZW: word = {e[0][3], e[0][2]};
            ROW1_XY: word = {e[1][1], e[1][0]};
            ROW1_ZW: word = {e[1][3], e[1][2]};
            ROW2_XY: word = {e[2][1], e[2][0]};
            ROW2_ZW: word = {e[2][3], e[2][2]};
            ROW3_XY: word = {e[3][1], e[3][0]};
            default: word = {e[3][3], e[3][2]};
         endcase
         csr_we    <= 1'b1;
         csr_index <= idx;
         csr_wdata <= word;
         @(posedge clock);
      end
      csr_we <= 1'b0;
      matrix_model = e;
   endtask

   task automatic wait_idle(int extra_cycles);
      req_valid <= 1'b0;
      while (expected_visibility.size() != 0)
         @(posedge clock);
      repeat (extra_cycles) @(posedge clock);
   endtask

   task automatic send_chunk(chunk_type cx, chunk_type cz, bit known, bit visible);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_chunk_x <= cx;
      req_chunk_z <= cz;
      do
         @(posedge clock);
      while (!req_ready);
      expected_visibility = {expected_visibility,
                             (known ? visible : predict_visible(cx, cz))};
   endtask

   initial begin : receiver
      bit expected;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (expected_visibility.size() == 0) begin
               $error("visible: result %0b with no transaction outstanding", rsp_visible);
               mismatch_count++;
            end else begin
               expected = expected_visibility.pop_front();
               if (rsp_visible !== expected) begin
                  $error("visible: expected %0b, actual %0b", expected, rsp_visible);
                  mismatch_count++;
               end
            end
         end
         if (hold_off_armed && !hold_off_taken) begin
            hold_off_taken = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("frustum_aabb_cull_unit: mismatch");
         $finish;
      end
   end

   initial begin : stimulus
      matrix_kind_type current;
      current = MAT_RESET;
      foreach (matrix_model[r, c])
         matrix_model[r][c] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind != current) begin
            current = directed_rows[i].kind;
            wait_idle(DRAIN_CYCLES);
            load_matrix(build_matrix(current));
         end
         send_chunk(directed_rows[i].cx, directed_rows[i].cz,
                    directed_rows[i].known, directed_rows[i].visible);
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         wait_idle(DRAIN_CYCLES);
         load_matrix(build_matrix(phase_kinds[phase]));
         if (phase < 2) begin
            send_idle_pct = 11;
            recv_idle_pct = 61;
         end else if (phase < 5) begin
            send_idle_pct = 61;
            recv_idle_pct = 11;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // The receiver stops for a long stretch so that the pipeline backs up.
         if (phase == 5)
            hold_off_armed = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_chunk(random_chunk(), random_chunk(), 1'b0, 1'b0);
      end

      wait_idle(TAIL_CYCLES);
      if (mismatch_count == 0 && expected_visibility.size() == 0)
         $display("frustum_aabb_cull_unit: match");
      else
         $display("frustum_aabb_cull_unit: mismatch");
      $finish;
   end

endmodule
